// File: hw/rtl/srds_pkg.sv
`timescale 1ns / 1ps
package srds_pkg;

    localparam int MaxRecords = 12;
    localparam int WindowLen  = 10;
    localparam int NumScalar  = 9;
    localparam int PtrW       = $clog2(WindowLen);
    localparam int RecW       = $clog2(MaxRecords + 1);

    typedef enum logic [1:0] {
        PH_CHANNEL = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_IDLE    = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        K_DIN = 4'd0, K_DOUT = 4'd1, K_AIN = 4'd2, K_AOUT = 4'd3,
        K_LUX = 4'd4, K_PRES = 4'd5, K_TEMP = 4'd6, K_HUM = 4'd7,
        K_ACCEL = 4'd8, K_BARO = 4'd9, K_GYRO = 4'd10, K_GPS = 4'd11
    } kind_t;

    typedef struct packed {
        logic        err;
        logic [7:0]  channel;
        kind_t       kind;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } rec_t;

    function automatic logic [3:0] kind_len(input kind_t k);
        case (k)
            K_DIN, K_DOUT, K_PRES, K_HUM: kind_len = 4'd1;
            K_ACCEL, K_GYRO:              kind_len = 4'd6;
            K_GPS:                        kind_len = 4'd9;
            default:                      kind_len = 4'd2;
        endcase
    endfunction

    function automatic logic kind_signed(input kind_t k);
        case (k)
            K_AIN, K_AOUT, K_TEMP, K_ACCEL, K_GYRO, K_GPS: kind_signed = 1'b1;
            default:                                       kind_signed = 1'b0;
        endcase
    endfunction

    function automatic logic [4:0] decode_type(input logic [7:0] b);
        unique case (b)
            8'd0:    decode_type = {1'b1, K_DIN};
            8'd1:    decode_type = {1'b1, K_DOUT};
            8'd2:    decode_type = {1'b1, K_AIN};
            8'd3:    decode_type = {1'b1, K_AOUT};
            8'd101:  decode_type = {1'b1, K_LUX};
            8'd102:  decode_type = {1'b1, K_PRES};
            8'd103:  decode_type = {1'b1, K_TEMP};
            8'd104:  decode_type = {1'b1, K_HUM};
            8'd113:  decode_type = {1'b1, K_ACCEL};
            8'd115:  decode_type = {1'b1, K_BARO};
            8'd134:  decode_type = {1'b1, K_GYRO};
            8'd136:  decode_type = {1'b1, K_GPS};
            default: decode_type = 5'd0;
        endcase
    endfunction

    function automatic logic [3:0] kind_slot(input kind_t k);
        kind_slot = (k == K_BARO) ? 4'd8 : k;
    endfunction

    function automatic logic [17:0] min_reset(input logic [3:0] s);
        case (s)
            4'd2, 4'd3:       min_reset = 18'sd100000;
            4'd5, 4'd6, 4'd8: min_reset = 18'sd10000;
            4'd7:             min_reset = 18'sd2000;
            default:          min_reset = 18'sd1000;
        endcase
    endfunction

endpackage

// File: hw/rtl/srds_fifo.sv
`timescale 1ns / 1ps
module srds_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  srds_pkg::rec_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output srds_pkg::rec_t rd_data,
    output logic           empty
);
    import srds_pkg::*;

    rec_t        mem_reg [2];
    logic [1:0]  wp_reg, rp_reg;

    assign full    = (wp_reg[0] == rp_reg[0]) && (wp_reg[1] != rp_reg[1]);
    assign empty   = (wp_reg == rp_reg);
    assign rd_data = mem_reg[rp_reg[0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en) rp_reg <= rp_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg[0]] <= wr_data;
    end
endmodule

// File: hw/rtl/srds_front.sv
`timescale 1ns / 1ps
module srds_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     data_byte,
    input  logic           frame_start,
    output logic           rec_valid,
    output srds_pkg::rec_t rec
);
    import srds_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [3:0]        idx_reg, idx_next;
    kind_t             kind_reg, kind_next;
    logic [7:0]        chan_reg, chan_next;
    logic [RecW-1:0]   nrec_reg, nrec_next;
    logic [7:0]        pay_reg [8];
    phase_t            ph;
    logic [RecW-1:0]   nr;
    logic [3:0]        ix;
    logic [4:0]        dt;
    logic              sg;

    always_comb
    begin
        ph = frame_start ? PH_CHANNEL : phase_reg;
        nr = frame_start ? '0 : nrec_reg;
        ix = frame_start ? 4'd0 : idx_reg;
        dt = decode_type(data_byte);
        phase_next = ph;
        idx_next   = ix;
        kind_next  = kind_reg;
        chan_next  = chan_reg;
        nrec_next  = nr;
        rec_valid  = 1'b0;
        unique case (ph)
            PH_CHANNEL:
            begin
                chan_next  = data_byte;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                if (!dt[4])
                begin
                    phase_next = PH_IDLE;
                    rec_valid  = 1'b1;
                end
                else
                begin
                    kind_next  = kind_t'(dt[3:0]);
                    idx_next   = 4'd0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                idx_next = ix + 4'd1;
                if (ix + 4'd1 >= kind_len(kind_reg))
                begin
                    rec_valid  = 1'b1;
                    idx_next   = 4'd0;
                    nrec_next  = nr + RecW'(1);
                    phase_next = (nr + RecW'(1) >= RecW'(MaxRecords)) ? PH_IDLE : PH_CHANNEL;
                end
            end
            default: ;
        endcase
        if (!in_fire) rec_valid = 1'b0;
    end

    always_comb
    begin
        sg = kind_signed(kind_reg);
        rec = '0;
        rec.channel = chan_reg;
        if (ph == PH_TYPE)
            rec.err = 1'b1;
        else
        begin
            rec.kind = kind_reg;
            case (kind_len(kind_reg))
                4'd1: rec.x = {16'd0, data_byte};
                4'd6:
                begin
                    rec.x = {{8{pay_reg[0][7]}}, pay_reg[0], pay_reg[1]};
                    rec.y = {{8{pay_reg[2][7]}}, pay_reg[2], pay_reg[3]};
                    rec.z = {{8{pay_reg[4][7]}}, pay_reg[4], data_byte};
                end
                4'd9:
                begin
                    rec.x = {pay_reg[0], pay_reg[1], pay_reg[2]};
                    rec.y = {pay_reg[3], pay_reg[4], pay_reg[5]};
                    rec.z = {pay_reg[6], pay_reg[7], data_byte};
                end
                default: rec.x = {{8{sg & pay_reg[0][7]}}, pay_reg[0], data_byte};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CHANNEL;
            idx_reg   <= '0;
            kind_reg  <= K_DIN;
            chan_reg  <= '0;
            nrec_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            kind_reg  <= kind_next;
            chan_reg  <= chan_next;
            nrec_reg  <= nrec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && ph == PH_PAYLOAD && ix < 4'd8) pay_reg[ix[2:0]] <= data_byte;
    end
endmodule

// File: hw/rtl/srds_back.sv
`timescale 1ns / 1ps
module srds_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  srds_pkg::rec_t     q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         channel,
    output logic [3:0]         sensor_kind,
    output logic               status,
    output logic signed [23:0] value_x,
    output logic signed [23:0] value_y,
    output logic signed [23:0] value_z,
    output logic signed [17:0] min_value,
    output logic signed [17:0] max_value,
    output logic signed [19:0] window_sum,
    output logic               digital_mean
);
    import srds_pkg::*;

    localparam int TotW = 17 + $clog2(WindowLen + 1);

    logic signed [16:0]    win_reg [NumScalar][WindowLen];
    logic signed [TotW-1:0] tot_reg [NumScalar];
    logic signed [17:0]    mn_reg  [NumScalar];
    logic signed [17:0]    mx_reg  [NumScalar];
    logic                  ov_reg;
    rec_t                  o_reg;
    logic signed [17:0]    omn_reg, omx_reg;
    logic signed [19:0]    osum_reg;
    logic                  odm_reg;

    logic                  scal;
    logic [3:0]            s;
    logic signed [17:0]    xv;
    logic signed [TotW-1:0] tn;
    logic signed [17:0]    mnn, mxn;
    logic signed [19:0]    sat;

    assign q_pop = !q_empty && (!ov_reg || !out_stall);

    always_comb
    begin
        scal = !q_data.err && q_data.kind != K_ACCEL && q_data.kind != K_GYRO
               && q_data.kind != K_GPS;
        s    = scal ? kind_slot(q_data.kind) : 4'd0;
        xv   = 18'(signed'(q_data.x));
        tn   = tot_reg[s] - TotW'(win_reg[s][WindowLen-1])
               + TotW'(signed'(xv[16:0]));
        mnn  = (xv < mn_reg[s]) ? xv : mn_reg[s];
        mxn  = (xv > mx_reg[s]) ? xv : mx_reg[s];
        if (tn > TotW'(524287))       sat = 20'sd524287;
        else if (tn < -TotW'(524288)) sat = -20'sd524288;
        else                          sat = 20'(tn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            for (int i = 0; i < NumScalar; i++)
            begin
                tot_reg[i] <= '0;
                mn_reg[i]  <= min_reset(4'(i));
                mx_reg[i]  <= '0;
                for (int j = 0; j < WindowLen; j++) win_reg[i][j] <= '0;
            end
        end
        else
        begin
            if (q_pop) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
            if (q_pop && scal)
            begin
                tot_reg[s] <= tn;
                win_reg[s][0] <= xv[16:0];
                for (int j = 1; j < WindowLen; j++) win_reg[s][j] <= win_reg[s][j-1];
                mn_reg[s] <= mnn;
                mx_reg[s] <= mxn;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            o_reg    <= q_data;
            omn_reg  <= scal ? mnn : '0;
            omx_reg  <= scal ? mxn : '0;
            osum_reg <= scal ? sat : '0;
            odm_reg  <= scal && (q_data.kind == K_DIN || q_data.kind == K_DOUT)
                        && (tn * 2 > TotW'(WindowLen));
        end
    end

    assign out_valid    = ov_reg;
    assign channel      = o_reg.channel;
    assign sensor_kind  = o_reg.kind;
    assign status       = o_reg.err;
    assign value_x      = o_reg.x;
    assign value_y      = o_reg.y;
    assign value_z      = o_reg.z;
    assign min_value    = omn_reg;
    assign max_value    = omx_reg;
    assign window_sum   = osum_reg;
    assign digital_mean = odm_reg;
endmodule

// File: hw/rtl/sensor_record_decoder_stats_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake        | payload
// in      | sink      | in_valid/in_stall | data_byte, frame_start
// out     | source    | out_valid/out_stall | channel .. digital_mean
// One byte per cycle while in_stall is low; records pass the queue and output register.
// Two-entry record queue between parser and statistics; in_stall rises when it is full.
// Reset clears parser, queue and statistics at once; minimums load per-kind values.
module sensor_record_decoder_stats_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         channel,
    output logic [3:0]         sensor_kind,
    output logic               status,
    output logic signed [23:0] value_x,
    output logic signed [23:0] value_y,
    output logic signed [23:0] value_z,
    output logic signed [17:0] min_value,
    output logic signed [17:0] max_value,
    output logic signed [19:0] window_sum,
    output logic               digital_mean
);
    import srds_pkg::*;

    logic in_fire, rec_valid, full, empty, pop;
    rec_t rec, qd;

    assign in_stall = full;
    assign in_fire  = in_valid && !full;

    srds_front u_front (.clk, .rst_n, .in_fire, .data_byte, .frame_start,
        .rec_valid, .rec);

    srds_fifo u_fifo (.clk, .rst_n, .wr_en(rec_valid), .wr_data(rec), .full,
        .rd_en(pop), .rd_data(qd), .empty);

    srds_back u_back (.clk, .rst_n, .q_empty(empty), .q_data(qd), .q_pop(pop),
        .out_valid, .out_stall, .channel, .sensor_kind, .status, .value_x,
        .value_y, .value_z, .min_value, .max_value, .window_sum, .digital_mean);
endmodule

// File: hw/rtl/srds_checker.sv
`timescale 1ns / 1ps
module srds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       status,
    input logic [3:0] sensor_kind,
    input logic       digital_mean
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("beat dropped");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid) else $error("input beat dropped");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> sensor_kind == 4'd0) else $error("error kind");
    a_dm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digital_mean |-> sensor_kind <= 4'd1) else $error("mean kind");
    a_rst: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("valid in reset");
endmodule

bind sensor_record_decoder_stats_core srds_checker u_chk (.clk, .rst_n, .in_valid,
    .in_stall, .out_valid, .out_stall, .status, .sensor_kind, .digital_mean);
